// ----- sv/qbf_pkg.sv -----
package qbf_pkg;

    // sizing of the curve datapath
    localparam int MAX_SEGMENTS = 64;
    localparam int COORD_BITS   = 16;
    localparam int SEG_CNT_W    = 7;
    localparam int CLR_W        = 32;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int FRAC_W       = 16;
    localparam int T_W          = FRAC_W + 1;
    localparam int DIV_CNT_W    = $clog2(T_W + 1);
    localparam int PROD_W       = COORD_BITS + 1 + T_W + 1;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [T_W-1:0]               tval_t;

    // one curve as handed from the front end to the segment engine
    typedef struct packed {
        coord_t             start_x;
        coord_t             start_y;
        coord_t             end_x;
        coord_t             end_y;
        coord_t             ctrl_x;
        coord_t             ctrl_y;
        cnt_t               count;
        tval_t              t_step;
        cnt_t               t_rem;
        logic [CLR_W-1:0]   color;
    } curve_desc_t;

    // a + floor((b - a) * t / 2^FRAC_W), result between a and b while t is at most 2^FRAC_W
    function automatic coord_t lerp(input coord_t a, input coord_t b, input tval_t t);
        logic signed [COORD_BITS:0] diff;
        logic signed [PROD_W-1:0]   prod;
        logic signed [PROD_W-1:0]   shifted;
        diff    = $signed({a[COORD_BITS-1], a});
        diff    = $signed({b[COORD_BITS-1], b}) - diff;
        prod    = diff * $signed({1'b0, t});
        shifted = prod >>> FRAC_W;
        return a + coord_t'(shifted[COORD_BITS-1:0]);
    endfunction

endpackage

// ----- sv/qbf_front.sv -----
module qbf_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  qbf_pkg::coord_t                s_start_x,
    input  qbf_pkg::coord_t                s_start_y,
    input  qbf_pkg::coord_t                s_end_x,
    input  qbf_pkg::coord_t                s_end_y,
    input  qbf_pkg::coord_t                s_ctrl_x,
    input  qbf_pkg::coord_t                s_ctrl_y,
    input  logic [qbf_pkg::SEG_CNT_W-1:0]  s_segment_count,
    input  logic [qbf_pkg::CLR_W-1:0]      s_line_color,
    output logic                           push_valid,
    input  logic                           push_ready,
    output qbf_pkg::curve_desc_t           push_desc
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    front_state_t                     state_reg;
    qbf_pkg::curve_desc_t             desc_reg;
    qbf_pkg::tval_t                   dvd_reg;
    qbf_pkg::tval_t                   quo_reg;
    qbf_pkg::cnt_t                    rem_reg;
    logic [qbf_pkg::DIV_CNT_W-1:0]    bits_reg;

    qbf_pkg::cnt_t              cnt_sat;
    logic [qbf_pkg::CNT_W:0]    trial;
    logic                       trial_ge;

    // clamp the requested segment count
    always_comb begin
        if (int'(s_segment_count) > qbf_pkg::MAX_SEGMENTS) begin
            cnt_sat = qbf_pkg::CNT_W'(qbf_pkg::MAX_SEGMENTS);
        end else begin
            cnt_sat = qbf_pkg::CNT_W'(s_segment_count);
        end
    end

    // restoring divide of 1.0 by the count, one quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, dvd_reg[qbf_pkg::T_W-1]};
        trial_ge = (trial >= {1'b0, desc_reg.count});
    end

    assign s_ready    = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);

    always_comb begin
        push_desc        = desc_reg;
        push_desc.t_step = quo_reg;
        push_desc.t_rem  = rem_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        desc_reg.start_x <= s_start_x;
                        desc_reg.start_y <= s_start_y;
                        desc_reg.end_x   <= s_end_x;
                        desc_reg.end_y   <= s_end_y;
                        desc_reg.ctrl_x  <= s_ctrl_x;
                        desc_reg.ctrl_y  <= s_ctrl_y;
                        desc_reg.count   <= cnt_sat;
                        desc_reg.color   <= s_line_color;
                        desc_reg.t_step  <= '0;
                        desc_reg.t_rem   <= '0;
                        dvd_reg          <= qbf_pkg::T_W'(1 << qbf_pkg::FRAC_W);
                        quo_reg          <= '0;
                        rem_reg          <= '0;
                        bits_reg         <= qbf_pkg::DIV_CNT_W'(qbf_pkg::T_W);
                        // an empty curve is dropped here
                        if (cnt_sat != '0) begin
                            state_reg <= F_DIV;
                        end
                    end
                end
                F_DIV: begin
                    dvd_reg  <= {dvd_reg[qbf_pkg::T_W-2:0], 1'b0};
                    quo_reg  <= {quo_reg[qbf_pkg::T_W-2:0], trial_ge};
                    bits_reg <= bits_reg - 1'b1;
                    if (trial_ge) begin
                        rem_reg <= qbf_pkg::CNT_W'(trial - {1'b0, desc_reg.count});
                    end else begin
                        rem_reg <= trial[qbf_pkg::CNT_W-1:0];
                    end
                    if (bits_reg == qbf_pkg::DIV_CNT_W'(1)) begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (push_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/qbf_queue.sv -----
module qbf_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  qbf_pkg::curve_desc_t  push_desc,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output qbf_pkg::curve_desc_t  pop_desc
);

    qbf_pkg::curve_desc_t         mem_reg [qbf_pkg::QDEPTH];
    logic [qbf_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [qbf_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [qbf_pkg::QPTR_W:0]     fill_reg;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (fill_reg != (qbf_pkg::QPTR_W + 1)'(qbf_pkg::QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_desc   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // descriptor storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= qbf_pkg::QPTR_W'((int'(wr_ptr_reg) + 1) % qbf_pkg::QDEPTH);
            end
            if (do_pop) begin
                rd_ptr_reg <= qbf_pkg::QPTR_W'((int'(rd_ptr_reg) + 1) % qbf_pkg::QDEPTH);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- sv/qbf_back.sv -----
module qbf_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  qbf_pkg::curve_desc_t       pop_desc,
    output logic                       m_valid,
    input  logic                       m_ready,
    output qbf_pkg::coord_t            m_from_x,
    output qbf_pkg::coord_t            m_from_y,
    output qbf_pkg::coord_t            m_to_x,
    output qbf_pkg::coord_t            m_to_y,
    output logic [qbf_pkg::CLR_W-1:0]  m_seg_color,
    output logic                       m_last_segment
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_LERP1,
        B_LERP2
    } back_state_t;

    back_state_t               state_reg;
    qbf_pkg::curve_desc_t      cur_reg;
    qbf_pkg::tval_t            t_reg;
    qbf_pkg::cnt_t             frac_reg;
    qbf_pkg::cnt_t             idx_reg;
    qbf_pkg::coord_t           prev_x_reg;
    qbf_pkg::coord_t           prev_y_reg;
    qbf_pkg::coord_t           p3x_reg;
    qbf_pkg::coord_t           p4x_reg;
    qbf_pkg::coord_t           p3y_reg;
    qbf_pkg::coord_t           p4y_reg;
    logic                      m_valid_reg;
    qbf_pkg::coord_t           from_x_reg;
    qbf_pkg::coord_t           from_y_reg;
    qbf_pkg::coord_t           to_x_reg;
    qbf_pkg::coord_t           to_y_reg;
    logic [qbf_pkg::CLR_W-1:0] color_reg;
    logic                      last_reg;

    logic                      out_free;
    logic                      load_out;
    logic                      is_last;
    qbf_pkg::coord_t           nx;
    qbf_pkg::coord_t           ny;
    logic [qbf_pkg::CNT_W:0]   frac_sum;
    qbf_pkg::cnt_t             frac_next;
    qbf_pkg::tval_t            t_next;

    assign pop_ready      = (state_reg == B_IDLE);
    assign out_free       = !m_valid_reg || m_ready;
    assign load_out       = (state_reg == B_LERP2) && out_free;
    assign is_last        = (idx_reg == cur_reg.count - 1'b1);
    assign m_valid        = m_valid_reg;
    assign m_from_x       = from_x_reg;
    assign m_from_y       = from_y_reg;
    assign m_to_x         = to_x_reg;
    assign m_to_y         = to_y_reg;
    assign m_seg_color    = color_reg;
    assign m_last_segment = last_reg;

    // second lerp level from the registered first level
    assign nx = qbf_pkg::lerp(p3x_reg, p4x_reg, t_reg);
    assign ny = qbf_pkg::lerp(p3y_reg, p4y_reg, t_reg);

    // next t = floor((i+2) * 2^FRAC_W / count) by quotient plus carried remainder
    always_comb begin
        frac_sum = {1'b0, frac_reg} + {1'b0, cur_reg.t_rem};
        if (frac_sum >= {1'b0, cur_reg.count}) begin
            frac_next = qbf_pkg::CNT_W'(frac_sum - {1'b0, cur_reg.count});
            t_next    = t_reg + cur_reg.t_step + 1'b1;
        end else begin
            frac_next = frac_sum[qbf_pkg::CNT_W-1:0];
            t_next    = t_reg + cur_reg.t_step;
        end
    end

    // segment sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // result valid set on a new segment, cleared once transferred
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (pop_valid) begin
                        cur_reg    <= pop_desc;
                        t_reg      <= pop_desc.t_step;
                        frac_reg   <= pop_desc.t_rem;
                        idx_reg    <= '0;
                        prev_x_reg <= pop_desc.start_x;
                        prev_y_reg <= pop_desc.start_y;
                        state_reg  <= B_LERP1;
                    end
                end
                B_LERP1: begin
                    p3x_reg   <= qbf_pkg::lerp(cur_reg.start_x, cur_reg.ctrl_x, t_reg);
                    p4x_reg   <= qbf_pkg::lerp(cur_reg.ctrl_x, cur_reg.end_x, t_reg);
                    p3y_reg   <= qbf_pkg::lerp(cur_reg.start_y, cur_reg.ctrl_y, t_reg);
                    p4y_reg   <= qbf_pkg::lerp(cur_reg.ctrl_y, cur_reg.end_y, t_reg);
                    state_reg <= B_LERP2;
                end
                B_LERP2: begin
                    if (out_free) begin
                        from_x_reg  <= prev_x_reg;
                        from_y_reg  <= prev_y_reg;
                        to_x_reg    <= nx;
                        to_y_reg    <= ny;
                        color_reg   <= cur_reg.color;
                        last_reg    <= is_last;
                        prev_x_reg  <= nx;
                        prev_y_reg  <= ny;
                        t_reg       <= t_next;
                        frac_reg    <= frac_next;
                        idx_reg     <= idx_reg + 1'b1;
                        state_reg   <= is_last ? B_IDLE : B_LERP1;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/quadratic_bezier_flattener_top.sv -----
// Quadratic Bezier flattener: each input transfer carries one curve (start, control and
// end point in signed Q.4, a segment count and a color); the block returns count line
// segments along it, chained end to start, the first starting at the curve start and
// the last flagged by m_last_segment and ending exactly at the curve end. Counts above
// 64 are clamped to 64, a count of zero produces nothing. The front end accepts a curve,
// derives the t step in a bit-serial divider and pushes the curve into a two-entry queue;
// it takes no new curve until the previous one is in the queue. The segment engine
// computes each segment in two chained multiplier stages for the de Casteljau lerps, and
// the next curve's divide overlaps the current curve's segments.
module quadratic_bezier_flattener_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  qbf_pkg::coord_t                s_start_x,
    input  qbf_pkg::coord_t                s_start_y,
    input  qbf_pkg::coord_t                s_end_x,
    input  qbf_pkg::coord_t                s_end_y,
    input  qbf_pkg::coord_t                s_ctrl_x,
    input  qbf_pkg::coord_t                s_ctrl_y,
    input  logic [qbf_pkg::SEG_CNT_W-1:0]  s_segment_count,
    input  logic [qbf_pkg::CLR_W-1:0]      s_line_color,
    output logic                           m_valid,
    input  logic                           m_ready,
    output qbf_pkg::coord_t                m_from_x,
    output qbf_pkg::coord_t                m_from_y,
    output qbf_pkg::coord_t                m_to_x,
    output qbf_pkg::coord_t                m_to_y,
    output logic [qbf_pkg::CLR_W-1:0]      m_seg_color,
    output logic                           m_last_segment
);

    logic                  push_valid;
    logic                  push_ready;
    qbf_pkg::curve_desc_t  push_desc;
    logic                  pop_valid;
    logic                  pop_ready;
    qbf_pkg::curve_desc_t  pop_desc;

    // intake, clamp and t step divide
    qbf_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_x       (s_start_x),
        .s_start_y       (s_start_y),
        .s_end_x         (s_end_x),
        .s_end_y         (s_end_y),
        .s_ctrl_x        (s_ctrl_x),
        .s_ctrl_y        (s_ctrl_y),
        .s_segment_count (s_segment_count),
        .s_line_color    (s_line_color),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_desc       (push_desc)
    );

    // curve queue between the two halves
    qbf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    // segment engine
    qbf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_desc       (pop_desc),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_from_x       (m_from_x),
        .m_from_y       (m_from_y),
        .m_to_x         (m_to_x),
        .m_to_y         (m_to_y),
        .m_seg_color    (m_seg_color),
        .m_last_segment (m_last_segment)
    );

endmodule

// ----- sv/qbf_checker.sv -----
module qbf_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  qbf_pkg::coord_t                m_from_x,
    input  qbf_pkg::coord_t                m_from_y,
    input  qbf_pkg::coord_t                m_to_x,
    input  qbf_pkg::coord_t                m_to_y,
    input  logic [qbf_pkg::CLR_W-1:0]      m_seg_color,
    input  logic                           m_last_segment
);

    logic                       chain_reg;
    qbf_pkg::coord_t            prev_to_x_reg;
    qbf_pkg::coord_t            prev_to_y_reg;
    logic [qbf_pkg::CLR_W-1:0]  prev_color_reg;

    // remember the last transferred segment of an unfinished curve
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            chain_reg      <= !m_last_segment;
            prev_to_x_reg  <= m_to_x;
            prev_to_y_reg  <= m_to_y;
            prev_color_reg <= m_seg_color;
        end
    end

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_to_x) && $stable(m_to_y))
        else $error("stalled result dropped or changed");

    // segments of one curve join end to start
    a_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && chain_reg |-> m_from_x == prev_to_x_reg && m_from_y == prev_to_y_reg)
        else $error("segment does not start where the previous one ended");

    // one color per curve
    a_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && chain_reg |-> m_seg_color == prev_color_reg)
        else $error("color changed inside a curve");

endmodule

bind quadratic_bezier_flattener_top qbf_checker u_qbf_checker (.*);
